// ===== hdl/qee_pkg.sv =====
// ----------------------------------------------------------------------------
// qee_pkg: shared types and constants for the queue edit engine
// Sizes, command and status codes, item and control structs.
// ----------------------------------------------------------------------------
package qee_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;

  typedef logic signed [WW-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_INSERT  = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_SPLIT   = 3'd5,
    CMD_REVERSE = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               has_value;
    logic               found;
    logic [1:0]         status;
    logic [6:0]         fill_level;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic pass2;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic walk;
    logic walk_done;
    logic need_pass2;
    logic need_out;
    logic out_busy;
    logic ins_point;
    logic fin_emit;
  } sts_t;

endpackage

// ===== hdl/qee_in_if.sv =====
// ----------------------------------------------------------------------------
// qee_in_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface qee_in_if;
  logic             valid;
  logic             ready;
  qee_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/qee_out_if.sv =====
// ----------------------------------------------------------------------------
// qee_out_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface qee_out_if;
  logic              valid;
  logic              ready;
  qee_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/qee_ram.sv =====
// ----------------------------------------------------------------------------
// qee_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/qee_ctrl.sv =====
// ----------------------------------------------------------------------------
// qee_ctrl: command sequencer
// Steps the datapath through dispatch, entry walk and final result.
// ----------------------------------------------------------------------------
module qee_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qee_pkg::sts_t sts,
  output qee_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD,
    S_PR,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = sts.walk ? S_RD : S_FIN;
      end
      S_RD: begin
        if (sts.walk_done) begin
          if (sts.need_pass2) begin
            ctl.pass2 = 1'b1;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          ctl.rd    = 1'b1;
          state_nxt = S_PR;
        end
      end
      S_PR: begin
        if (!(sts.need_out && sts.out_busy)) begin
          ctl.step  = 1'b1;
          state_nxt = sts.ins_point ? S_PR : S_RD;
        end
      end
      S_FIN: begin
        // fin rewrites the result register, so a waiting split item goes first
        if (!sts.out_busy) begin
          ctl.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/qee_dp.sv =====
// ----------------------------------------------------------------------------
// qee_dp: queue datapath
// Two entry banks; edits copy the queue into the idle bank in new order.
// ----------------------------------------------------------------------------
module qee_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  qee_pkg::in_item_t  in_data,
  input  qee_pkg::ctl_t      ctl,
  output qee_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output qee_pkg::out_item_t out_data
);

  localparam int AW = qee_pkg::AW;
  localparam int CW = qee_pkg::CW;

  logic [2:0]         cmd_r;
  qee_pkg::word_t     val_r;
  logic [6:0]         pos_r;
  logic               bank_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      cnt_r, i_r, w_r, nt_r, ne_r;
  logic               pass2_r, ins_done_r, found_r;
  logic [AW-1:0]      rd_addr_r;
  logic               out_valid_r;
  qee_pkg::out_item_t out_r;

  qee_pkg::word_t     rd0, rd1, d;
  logic [AW-1:0]      phys, ram_rd_addr;
  logic               wr0, wr1, wr_en, wr_bank;
  logic [AW-1:0]      wr_addr;
  qee_pkg::word_t     wr_data;
  logic [CW-1:0]      n_walk, keep_n;
  logic               is_full, reject, less, taken;
  logic               out_busy;

  qee_ram #(.WIDTH(qee_pkg::WW), .DEPTH(qee_pkg::DEPTH)) u_bank0 (
    .clk(clk), .wr_en(wr0), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(ram_rd_addr), .rd_data(rd0)
  );

  qee_ram #(.WIDTH(qee_pkg::WW), .DEPTH(qee_pkg::DEPTH)) u_bank1 (
    .clk(clk), .wr_en(wr1), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(ram_rd_addr), .rd_data(rd1)
  );

  assign d       = bank_r ? rd1 : rd0;
  assign is_full = (cnt_r == CW'(qee_pkg::DEPTH));
  assign reject  = (pos_r == 7'd0) || (CW'(pos_r) > cnt_r) || is_full;
  assign less    = (d < val_r);
  assign taken   = (cmd_r == qee_pkg::CMD_SPLIT) && pass2_r && less;
  assign n_walk  = (cmd_r == qee_pkg::CMD_POP) ? CW'(1) : cnt_r;
  assign keep_n  = cnt_r - nt_r;
  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    if (cmd_r == qee_pkg::CMD_REVERSE) begin
      phys = AW'(CW'(head_r) + cnt_r - CW'(1) - i_r);
    end else begin
      phys = AW'(CW'(head_r) + i_r);
    end
  end

  assign ram_rd_addr = ctl.rd ? phys : rd_addr_r;

  always_comb begin
    sts.walk = 1'b0;
    case (cmd_r)
      qee_pkg::CMD_POP:     sts.walk = (cnt_r != '0);
      qee_pkg::CMD_SEARCH,
      qee_pkg::CMD_REMOVE,
      qee_pkg::CMD_SPLIT,
      qee_pkg::CMD_REVERSE: sts.walk = 1'b1;
      qee_pkg::CMD_INSERT:  sts.walk = !reject;
      default:              sts.walk = 1'b0;
    endcase
    sts.walk_done  = (i_r == n_walk);
    sts.need_pass2 = (cmd_r == qee_pkg::CMD_SPLIT) && !pass2_r;
    sts.need_out   = taken;
    sts.out_busy   = out_busy;
    sts.ins_point  = (cmd_r == qee_pkg::CMD_INSERT) && !ins_done_r &&
                     (i_r == CW'(pos_r) - CW'(1));
    sts.fin_emit   = !((cmd_r == qee_pkg::CMD_SPLIT) && (nt_r != '0));
  end

  // write port: walk copies go to the idle bank, push to the live bank
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = !bank_r;
    wr_addr = w_r[AW-1:0];
    wr_data = d;
    if (ctl.step) begin
      case (cmd_r)
        qee_pkg::CMD_INSERT: begin
          wr_en = 1'b1;
          if (sts.ins_point) wr_data = val_r;
        end
        qee_pkg::CMD_REMOVE:  wr_en = (d != val_r);
        qee_pkg::CMD_SPLIT:   wr_en = pass2_r && !less;
        qee_pkg::CMD_REVERSE: wr_en = 1'b1;
        default:              wr_en = 1'b0;
      endcase
    end else if (ctl.fin && cmd_r == qee_pkg::CMD_PUSH && !is_full) begin
      wr_en   = 1'b1;
      wr_bank = bank_r;
      wr_addr = AW'(CW'(head_r) + cnt_r);
      wr_data = val_r;
    end
  end

  assign wr0 = wr_en && !wr_bank;
  assign wr1 = wr_en && wr_bank;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (ctl.load) begin
        cmd_r      <= in_data.cmd;
        val_r      <= qee_pkg::word_t'(in_data.value);
        pos_r      <= in_data.position;
        i_r        <= '0;
        w_r        <= '0;
        nt_r       <= '0;
        ne_r       <= '0;
        pass2_r    <= 1'b0;
        ins_done_r <= 1'b0;
        found_r    <= 1'b0;
      end

      if (ctl.rd) rd_addr_r <= phys;

      if (ctl.pass2) begin
        pass2_r <= 1'b1;
        i_r     <= '0;
      end

      if (ctl.step) begin
        if (sts.ins_point) begin
          ins_done_r <= 1'b1;
        end else begin
          i_r <= i_r + CW'(1);
        end
        if (wr_en) w_r <= w_r + CW'(1);
        if (cmd_r == qee_pkg::CMD_SEARCH && d == val_r) found_r <= 1'b1;
        if (cmd_r == qee_pkg::CMD_SPLIT && !pass2_r && less) nt_r <= nt_r + CW'(1);
        if (taken) begin
          ne_r                 <= ne_r + CW'(1);
          out_valid_r          <= 1'b1;
          out_r.out_value      <= 32'(d);
          out_r.has_value      <= 1'b1;
          out_r.found          <= 1'b0;
          out_r.status         <= qee_pkg::ST_OK;
          out_r.fill_level     <= 7'(keep_n);
          out_r.last           <= (ne_r + CW'(1) == nt_r);
        end
      end

      if (ctl.fin) begin
        out_r.out_value  <= '0;
        out_r.has_value  <= 1'b0;
        out_r.found      <= 1'b0;
        out_r.status     <= qee_pkg::ST_OK;
        out_r.fill_level <= 7'(cnt_r);
        out_r.last       <= 1'b1;
        if (sts.fin_emit) out_valid_r <= 1'b1;
        case (cmd_r)
          qee_pkg::CMD_PUSH: begin
            if (is_full) begin
              out_r.status <= qee_pkg::ST_FULL;
            end else begin
              cnt_r            <= cnt_r + CW'(1);
              out_r.fill_level <= 7'(cnt_r + CW'(1));
            end
          end
          qee_pkg::CMD_POP: begin
            if (cnt_r == '0) begin
              out_r.status <= qee_pkg::ST_EMPTY;
            end else begin
              head_r           <= head_r + AW'(1);
              cnt_r            <= cnt_r - CW'(1);
              out_r.fill_level <= 7'(cnt_r - CW'(1));
              out_r.out_value  <= 32'(d);
              out_r.has_value  <= 1'b1;
            end
          end
          qee_pkg::CMD_SEARCH: out_r.found <= found_r;
          qee_pkg::CMD_INSERT: begin
            if ((pos_r == 7'd0) || (CW'(pos_r) > cnt_r)) begin
              out_r.status <= qee_pkg::ST_BADPOS;
            end else if (is_full) begin
              out_r.status <= qee_pkg::ST_FULL;
            end else begin
              bank_r           <= !bank_r;
              head_r           <= '0;
              cnt_r            <= w_r;
              out_r.fill_level <= 7'(w_r);
            end
          end
          qee_pkg::CMD_REMOVE,
          qee_pkg::CMD_SPLIT,
          qee_pkg::CMD_REVERSE: begin
            bank_r           <= !bank_r;
            head_r           <= '0;
            cnt_r            <= w_r;
            out_r.fill_level <= 7'(w_r);
          end
          default: out_r.status <= qee_pkg::ST_OK;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/queue_edit_engine.sv =====
// ----------------------------------------------------------------------------
// queue_edit_engine: bounded queue with in-place edit commands
// Push, pop, search, insert, remove, split and reverse on a 64-entry queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one command item (cmd, value, position); it is taken when
//   valid and ready are both high. Ready is high only while the engine is
//   idle, so one command is worked on at a time.
//   out_if carries result items; every command gives one, except split,
//   which gives one per entry taken out (or one with has_value low if none).
//   The item with last high ends the results of a command.
// Work per command: push and immediate rejects go straight to the result
//   register; pop reads its head entry first. Search, remove and reverse
//   walk every entry with one RAM read and one process step each, insert
//   adds one process step for the new entry, and split walks twice (count,
//   then extract).
//   The next command can be taken in the cycle after the final result is loaded.
// Edit walks copy entries in their new order into the second RAM bank,
//   which then becomes live; the single read port sets the per-entry cost.
// Reset clears the fill level and head pointer; RAM contents are left as is.
// A stalled receiver holds the engine in its current step until the output
//   register is free; nothing is dropped.
// ----------------------------------------------------------------------------
module queue_edit_engine (
  input logic       clk,
  input logic       rst_n,
  qee_in_if.sink    in_if,
  qee_out_if.source out_if
);

  qee_pkg::ctl_t ctl;
  qee_pkg::sts_t sts;

  qee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  qee_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_if.data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
  );

endmodule
